[rtl/core/ssf4_pkg.sv]
// Shared constants, types and coefficient tables of the fourth-order
// state-space filter. Depends on nothing; every file but ssf4_checker uses it.
`default_nettype none

package ssf4_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int STATE_WIDTH_DEF  = 48;
   localparam int OUT_W            = 32;
   localparam int NUM_STATES       = 4;
   localparam int NUM_FORMS        = 2;

   // A is Q4.20, B Q11.20, C Q-7.20; state and output have 16 fraction bits.
   localparam int COEF_FRAC  = 20;
   localparam int STATE_FRAC = 16;

   // Coefficient widths are the narrowest signed widths that hold the tables.
   localparam int ACOEF_W = 24;
   localparam int BCOEF_W = 31;
   localparam int CCOEF_W = 13;

   typedef enum logic {
      FORM_COMPANION = 1'b0,
      FORM_MODAL     = 1'b1
   } form_type;

   localparam form_type FORM_RESET = FORM_MODAL;

   typedef logic signed [ACOEF_W-1:0] acoef_type;
   typedef logic signed [BCOEF_W-1:0] bcoef_type;
   typedef logic signed [CCOEF_W-1:0] ccoef_type;

   localparam acoef_type COEF_A [NUM_FORMS][NUM_STATES][NUM_STATES] = '{
      '{ '{ 24'sd3657957, -24'sd4815271, 24'sd2832518, -24'sd627887 },
         '{ 24'sd1048576, 24'sd0,        24'sd0,        24'sd0       },
         '{ 24'sd0,       24'sd1048576,  24'sd0,        24'sd0       },
         '{ 24'sd0,       24'sd0,        24'sd1048576,  24'sd0       } },
      '{ '{ 24'sd957245,  24'sd175532,   24'sd0,        24'sd0       },
         '{ -24'sd175532, 24'sd957245,   24'sd0,        24'sd0       },
         '{ 24'sd0,       24'sd0,        24'sd871786,   24'sd66165   },
         '{ 24'sd0,       24'sd0,        -24'sd66165,   24'sd871786  } }
   };

   localparam bcoef_type COEF_B [NUM_FORMS][NUM_STATES] = '{
      '{ 31'sd1048576, 31'sd0, 31'sd0, 31'sd0 },
      '{ -31'sd294087085, -31'sd187363439, 31'sd258974679, 31'sd771702129 }
   };

   localparam ccoef_type COEF_C [NUM_FORMS][NUM_STATES] = '{
      '{ 13'sd2831, 13'sd524, 13'sd2517, 13'sd105 },
      '{ 13'sd2726, 13'sd944, 13'sd2621, 13'sd419 }
   };

endpackage

`default_nettype wire

[rtl/core/ssf4_sample_if.sv]
// Valid/ready channel carrying one input sample per transaction.
// Depends on ssf4_pkg for the default sample width.
`default_nettype none

interface ssf4_sample_if #(
   parameter int SAMPLE_WIDTH = ssf4_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

[rtl/core/ssf4_result_if.sv]
// Valid/ready channel carrying one filter output per transaction.
// Depends on ssf4_pkg for the output width.
`default_nettype none

interface ssf4_result_if;
   import ssf4_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] filtered_out;

   modport source (output valid, output filtered_out, input ready);
   modport sink   (input valid, input filtered_out, output ready);
endinterface

`default_nettype wire

[rtl/core/ssf4_row.sv]
// One row of the state-space update: four coefficient-by-state products plus
// an optional input term, rounded to 16 fraction bits and saturated.
// Depends on ssf4_pkg.
`default_nettype none

module ssf4_row #(
   parameter int STATE_WIDTH  = ssf4_pkg::STATE_WIDTH_DEF,
   parameter int SAMPLE_WIDTH = ssf4_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_W       = ssf4_pkg::ACOEF_W,
   parameter int RES_W        = ssf4_pkg::STATE_WIDTH_DEF
) (
   input  logic signed [STATE_WIDTH-1:0]       x_vec  [ssf4_pkg::NUM_STATES],
   input  logic signed [COEF_W-1:0]            coef   [ssf4_pkg::NUM_STATES],
   input  logic signed [ssf4_pkg::BCOEF_W-1:0] b_coef,
   input  logic signed [SAMPLE_WIDTH-1:0]      sample,
   output logic signed [RES_W-1:0]             result
);
   import ssf4_pkg::*;

   localparam int U_W   = SAMPLE_WIDTH + STATE_FRAC;
   localparam int PA_W  = STATE_WIDTH + COEF_W;
   localparam int PB_W  = U_W + BCOEF_W;
   // Three guard bits cover the sum of five terms and the rounding offset.
   localparam int ACC_W = ((PA_W > PB_W) ? PA_W : PB_W) + 3;
   localparam int SH_W  = ACC_W - COEF_FRAC;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC - 1);
   localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
   localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

   logic signed [U_W-1:0]   u_val;
   logic signed [PA_W-1:0]  prod_a [NUM_STATES];
   logic signed [PB_W-1:0]  prod_b;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] rounded;
   logic signed [SH_W-1:0]  shifted;
   logic [SH_W-RES_W:0]     top_bits;
   logic                    in_range;

   assign u_val = {sample, {STATE_FRAC{1'b0}}};

   always_comb begin
      for (int j = 0; j < NUM_STATES; j++) begin
         prod_a[j] = x_vec[j] * coef[j];
      end
   end

   assign prod_b = u_val * b_coef;

   assign acc = ACC_W'(prod_a[0]) + ACC_W'(prod_a[1]) + ACC_W'(prod_a[2])
              + ACC_W'(prod_a[3]) + ACC_W'(prod_b);

   assign rounded  = acc + HALF;
   assign shifted  = $signed(rounded[ACC_W-1:COEF_FRAC]);
   assign top_bits = shifted[SH_W-1:RES_W-1];
   assign in_range = (&top_bits) || !(|top_bits);

   always_comb begin
      if (in_range) begin
         result = shifted[RES_W-1:0];
      end else if (shifted[SH_W-1]) begin
         result = RES_MIN;
      end else begin
         result = RES_MAX;
      end
   end

endmodule

`default_nettype wire

[rtl/core/state_space_filter_4th_order.sv]
// Fourth-order state-space filter. An accepted transaction passes through
// the input register, then the result register. Throughput: one transaction
// per cycle while no result is held back; the feedback through the four
// state rows is combinational. Reset clears both valid flags and the state
// and selects the modal coefficients; a CSR write clears the state.
// Depends on ssf4_pkg, ssf4_sample_if, ssf4_result_if and ssf4_row.
`default_nettype none

module state_space_filter_4th_order #(
   parameter int SAMPLE_WIDTH = ssf4_pkg::SAMPLE_WIDTH_DEF,
   parameter int STATE_WIDTH  = ssf4_pkg::STATE_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   ssf4_sample_if.sink   req_chan,
   ssf4_result_if.source rsp_chan,
   input  logic          csr_we,
   input  logic          csr_wdata
);
   import ssf4_pkg::*;

   form_type                       mode_ff;
   logic                           in_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff;
   logic                           out_valid_ff;
   logic signed [OUT_W-1:0]        out_data_ff;
   logic signed [OUT_W-1:0]        out_data_in;
   logic signed [STATE_WIDTH-1:0]  state_ff [NUM_STATES];
   logic signed [STATE_WIDTH-1:0]  state_in [NUM_STATES];

   acoef_type a_sel [NUM_STATES][NUM_STATES];
   bcoef_type b_sel [NUM_STATES];
   ccoef_type c_sel [NUM_STATES];

   logic advance;
   logic req_fire;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.filtered_out = out_data_ff;

   always_comb begin
      for (int r = 0; r < NUM_STATES; r++) begin
         b_sel[r] = COEF_B[mode_ff][r];
         c_sel[r] = COEF_C[mode_ff][r];
         for (int c = 0; c < NUM_STATES; c++) begin
            a_sel[r][c] = COEF_A[mode_ff][r][c];
         end
      end
   end

   // The output row sees the state held before this transaction's update.
   ssf4_row #(
      .STATE_WIDTH  (STATE_WIDTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_W       (CCOEF_W),
      .RES_W        (OUT_W)
   ) u_out_row (
      .x_vec  (state_ff),
      .coef   (c_sel),
      .b_coef ('0),
      .sample ('0),
      .result (out_data_in)
   );

   for (genvar i = 0; i < NUM_STATES; i++) begin : g_state_row
      ssf4_row #(
         .STATE_WIDTH  (STATE_WIDTH),
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .COEF_W       (ACOEF_W),
         .RES_W        (STATE_WIDTH)
      ) u_row (
         .x_vec  (state_ff),
         .coef   (a_sel[i]),
         .b_coef (b_sel[i]),
         .sample (in_sample_ff),
         .result (state_in[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= FORM_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_STATES; i++) begin
            state_ff[i] <= '0;
         end
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end

         if (csr_we) begin
            mode_ff <= form_type'(csr_wdata);
            for (int i = 0; i < NUM_STATES; i++) begin
               state_ff[i] <= '0;
            end
         end else if (advance) begin
            for (int i = 0; i < NUM_STATES; i++) begin
               state_ff[i] <= state_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_sample_ff <= req_chan.sample_in;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/ssf4_checker.sv]
// Port-level checks of the state-space filter, attached by the bind below.
// Depends only on the top level's ports.
`default_nettype none

module ssf4_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // No result survives a reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A transaction followed by a free output reaches the result register.
   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("accepted transaction did not produce a result in time");

   // The input side stalls only because a result is held back.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without output back-pressure");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind state_space_filter_4th_order ssf4_checker u_ssf4_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);

`default_nettype wire

[dv/ssf4_filter_checker.sv]
// Scoreboard for the fourth-order state-space filter: predicts each output from
// the accepted samples and compares it with the result channel.
// Depends on ssf4_pkg for the coefficient form type.
`default_nettype none

module ssf4_filter_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_sample,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_filtered,
   input  logic               csr_we,
   input  logic               csr_wdata,
   output int                 mismatch_count,
   output int                 pending_count
);
   import ssf4_pkg::*;

   form_type           form_sel;
   logic signed [47:0] state_x [4];
   logic signed [31:0] expected_out [$];
   int                 fails   = 0;
   int                 waiting = 0;

   assign mismatch_count = fails;
   assign pending_count  = waiting;

   // Coefficient rows are packed four 32-bit Q12.20 words, column 0 first.
   function automatic int a_coef(input form_type f, input int r, input int c);
      logic [127:0] row;
      if (f == FORM_COMPANION) begin
         case (r)
            0: row = {32'sd3657957, -32'sd4815271, 32'sd2832518, -32'sd627887};
            1: row = {32'sd1048576, 32'sd0, 32'sd0, 32'sd0};
            2: row = {32'sd0, 32'sd1048576, 32'sd0, 32'sd0};
            default: row = {32'sd0, 32'sd0, 32'sd1048576, 32'sd0};
         endcase
      end else begin
         case (r)
            0: row = {32'sd957245, 32'sd175532, 32'sd0, 32'sd0};
            1: row = {-32'sd175532, 32'sd957245, 32'sd0, 32'sd0};
            2: row = {32'sd0, 32'sd0, 32'sd871786, 32'sd66165};
            default: row = {32'sd0, 32'sd0, -32'sd66165, 32'sd871786};
         endcase
      end
      return row[(3 - c) * 32 +: 32];
   endfunction

   function automatic int b_coef(input form_type f, input int r);
      logic [127:0] col;
      if (f == FORM_COMPANION) begin
         col = {32'sd1048576, 32'sd0, 32'sd0, 32'sd0};
      end else begin
         col = {-32'sd294087085, -32'sd187363439, 32'sd258974679, 32'sd771702129};
      end
      return col[(3 - r) * 32 +: 32];
   endfunction

   function automatic int c_coef(input form_type f, input int c);
      logic [127:0] row;
      if (f == FORM_COMPANION) begin
         row = {32'sd2831, 32'sd524, 32'sd2517, 32'sd105};
      end else begin
         row = {32'sd2726, 32'sd944, 32'sd2621, 32'sd419};
      end
      return row[(3 - c) * 32 +: 32];
   endfunction

   // Drops 36 fraction bits to 16 with round half up, then clamps to w bits.
   function automatic logic signed [95:0] round_sat(input logic signed [95:0] acc,
                                                    input int w);
      logic signed [95:0] r, hi, lo;
      r  = (acc + 96'sd524288) >>> 20;
      hi = (96'sd1 <<< (w - 1)) - 96'sd1;
      lo = -hi - 96'sd1;
      if (r > hi) return hi;
      if (r < lo) return lo;
      return r;
   endfunction

   // Output comes from the state held before this sample; then the state moves.
   function automatic logic signed [31:0] advance_filter(input logic signed [15:0] value);
      logic signed [95:0] acc, u_fix;
      logic signed [95:0] xw [4];
      logic signed [47:0] next_x [4];
      logic signed [31:0] y;
      int i, j;
      for (j = 0; j < 4; j++) xw[j] = 96'(state_x[j]);
      u_fix = 96'(value) <<< 16;
      acc = '0;
      for (j = 0; j < 4; j++) acc = acc + 96'(c_coef(form_sel, j)) * xw[j];
      y = 32'(round_sat(acc, 32));
      for (i = 0; i < 4; i++) begin
         acc = 96'(b_coef(form_sel, i)) * u_fix;
         for (j = 0; j < 4; j++) acc = acc + 96'(a_coef(form_sel, i, j)) * xw[j];
         next_x[i] = 48'(round_sat(acc, 48));
      end
      for (i = 0; i < 4; i++) state_x[i] = next_x[i];
      return y;
   endfunction

   always @(posedge clock) begin : watch
      logic signed [31:0] want;
      if (reset) begin
         form_sel = FORM_MODAL;
         for (int k = 0; k < 4; k++) state_x[k] = '0;
         expected_out.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_out.size() == 0) begin
               $display("%0t: unexpected result transaction, got %0d, expected none",
                        $time, rsp_filtered);
               fails++;
            end else begin
               want = expected_out.pop_front();
               if (rsp_filtered !== want) begin
                  $display("%0t: filtered_out expected %0d, got %0d",
                           $time, want, rsp_filtered);
                  fails++;
               end
            end
         end
         // Any write of the mode clears the state, even with an unchanged value.
         if (csr_we) begin
            form_sel = form_type'(csr_wdata);
            for (int k = 0; k < 4; k++) state_x[k] = '0;
         end
         if (req_valid && req_ready) expected_out.push_back(advance_filter(req_sample));
      end
      waiting <= expected_out.size();
   end

endmodule

`default_nettype wire

[dv/tb_state_space_filter_4th_order.sv]
// Top of the state-space filter testbench: clock, reset, sample and mode stimulus
// and the verdict. Depends on ssf4_pkg, both channel interfaces and the checker.
`default_nettype none

module tb_state_space_filter_4th_order;
   import ssf4_pkg::*;

   localparam int ITEM_TARGET = 1800;
   localparam int IDLE_LIMIT  = 500;

   typedef enum int {
      SHAPE_NOISE,
      SHAPE_SMALL,
      SHAPE_RAIL,
      SHAPE_STEP
   } shape_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_wdata;
   int   mismatch_count;
   int   pending_count;
   bit   sender_quiet = 1'b0;

   always #5 clock = ~clock;

   ssf4_sample_if req_chan ();
   ssf4_result_if rsp_chan ();

   state_space_filter_4th_order u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   ssf4_filter_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_sample     (req_chan.sample_in),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_filtered   (rsp_chan.filtered_out),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Drives valid with the sample, after a random gap unless the sender is quiet, and waits for ready.
   task automatic send_sample(input logic signed [15:0] value);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.sample_in <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // The pending count is registered, so it lags the checker's queue.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_mode(input form_type mode);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int sent, phase_len, seg_len, k, n;
      shape_type shape;
      logic signed [15:0] held, value;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= 1'b0;
      req_chan.valid     <= 1'b0;
      req_chan.sample_in <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Modal form out of reset: rails, unit steps and alternating bit patterns.
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      send_sample(16'sh0001);
      send_sample(16'shFFFF);
      send_sample(16'sh5555);
      send_sample(16'shAAAA);
      send_sample(16'sh0000);
      // Rewriting the same mode must still clear the state.
      write_mode(FORM_MODAL);
      send_sample(16'sh7FFF);
      send_sample(16'sh0000);
      send_sample(16'sh0000);
      write_mode(FORM_COMPANION);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh5555);
      send_sample(16'shAAAA);
      send_sample(16'sh0001);
      send_sample(16'shFFFF);
      send_sample(16'sh0000);
      send_sample(16'sh0000);

      // Random phases, each under a freshly written mode. Long rail segments
      // drive the output into saturation in both directions.
      sent = 0;
      while (sent < ITEM_TARGET) begin
         write_mode(form_type'($urandom_range(0, 1)));
         phase_len = $urandom_range(150, 400);
         k = 0;
         while (k < phase_len && sent < ITEM_TARGET) begin
            shape        = shape_type'($urandom_range(0, 3));
            seg_len      = $urandom_range(20, 120);
            if (seg_len > ITEM_TARGET - sent) seg_len = ITEM_TARGET - sent;
            sender_quiet = ($urandom_range(0, 3) == 0);
            held         = 16'($urandom);
            if (shape == SHAPE_RAIL) held = held[15] ? 16'sh8000 : 16'sh7FFF;
            for (n = 0; n < seg_len; n++) begin
               case (shape)
                  SHAPE_NOISE: value = 16'($urandom);
                  SHAPE_SMALL: value = 16'($urandom_range(0, 512) - 256);
                  default:     value = held;
               endcase
               send_sample(value);
            end
            k    += seg_len;
            sent += seg_len;
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Result side: a random stall before each result, with stretches of none.
   initial begin : drain
      int stall, quiet_left;
      bit quiet;
      quiet_left = 0;
      quiet      = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (quiet_left == 0) begin
            quiet      = ($urandom_range(0, 3) == 0);
            quiet_left = $urandom_range(20, 100);
         end
         quiet_left--;
         stall = quiet ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || csr_we) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
